/* rtl/nwpm_pkg.sv */
// Shared constants, codes and controller/datapath types for the word match search.
package nwpm_pkg;

	localparam int MAX_PASS_LEN = 11;
	localparam int BEST_DEPTH   = 16;
	localparam int PASS_BYTES   = 11;
	localparam int PB_IDX_W     = $clog2(PASS_BYTES);
	localparam int LEN_CAP_INT  = (MAX_PASS_LEN < PASS_BYTES) ? MAX_PASS_LEN : PASS_BYTES;
	localparam logic [3:0] LEN_CAP = 4'(LEN_CAP_INT);
	localparam int ADDR_W       = (BEST_DEPTH > 1) ? $clog2(BEST_DEPTH) : 1;
	localparam int KEPT_W       = $clog2(BEST_DEPTH + 1);
	localparam int OUT_KEPT_W   = 5;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam int CFG_DATA_W   = 64;

	typedef enum logic [1:0] {
		REG_PASS_LO  = 2'd0,
		REG_PASS_HI  = 2'd1,
		REG_PASS_LEN = 2'd2
	} reg_index_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_FLUSH = 1'b1
	} in_kind_t;

	typedef enum logic [1:0] {
		RK_VERDICT = 2'd0,
		RK_ENTRY   = 2'd1,
		RK_SUMMARY = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		VERD_WORSE    = 2'd0,
		VERD_TIE      = 2'd1,
		VERD_NEW_BEST = 2'd2,
		VERD_EXACT    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FL_WAIT,
		ST_FL_EMIT,
		ST_FL_SUM
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic flush_start;
		logic emit_entry;
		logic emit_summary;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic list_empty;
		logic idx_last;
	} sts_t;

endpackage

/* rtl/nwpm_if.sv */
// Input and result channel interfaces (valid/ready with payload).
interface nwpm_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] list_byte;

	modport source(output valid, kind, list_byte, input ready);
	modport sink(input valid, kind, list_byte, output ready);
endinterface

interface nwpm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] word_number;
	logic [7:0]  distance;
	logic [1:0]  verdict;
	logic [4:0]  kept_total;
	logic        list_overflowed;
	logic        last_result;

	modport source(output valid, result_kind, word_number, distance, verdict, kept_total,
		list_overflowed, last_result, input ready);
	modport sink(input valid, result_kind, word_number, distance, verdict, kept_total,
		list_overflowed, last_result, output ready);
endinterface

/* rtl/nwpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nwpm_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/nwpm_ctrl.sv */
// Controller: input acceptance and the flush walk over the kept list.
module nwpm_ctrl import nwpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (in_kind == KIND_FLUSH) begin
						cmd.flush_start = 1'b1;
						state_d = sts.list_empty ? ST_FL_SUM : ST_FL_WAIT;
					end else begin
						cmd.take_byte = 1'b1;
					end
				end
			end
			// read data for the current index lands at the end of this cycle
			ST_FL_WAIT: begin
				state_d = ST_FL_EMIT;
			end
			ST_FL_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_entry = 1'b1;
					state_d = sts.idx_last ? ST_FL_SUM : ST_FL_WAIT;
				end
			end
			ST_FL_SUM: begin
				if (sts.out_free) begin
					cmd.emit_summary = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/nwpm_dp.sv */
// Datapath: password registers, word counters, grading, kept list and result register.
module nwpm_dp import nwpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [7:0]            in_byte,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	nwpm_out_if.source            out_ch
);

	// configuration
	logic [63:0] pass_lo_q;
	logic [23:0] pass_hi_q;
	logic [3:0]  len_q;

	// search state
	logic [7:0]        pos_q;
	logic [3:0]        match_q;
	logic [15:0]       wnum_q;
	logic [7:0]        best_q;
	logic [KEPT_W-1:0] kept_q;
	logic              ovf_q;
	logic              done_q;
	logic [KEPT_W-1:0] idx_q;

	// result register
	logic        ov_q;
	logic [1:0]  okind_q;
	logic [15:0] own_q;
	logic [7:0]  odist_q;
	logic [1:0]  overd_q;
	logic [4:0]  okept_q;
	logic        oovf_q;
	logic        olast_q;

	logic [PASS_BYTES-1:0][7:0] pass_bytes;
	logic [3:0]        eff_len, new_len, search_len;
	logic [7:0]        eff_len8, longer, word_dist;
	logic              byte_hit, ch, nl, keep, better, room, restart;
	logic [KEPT_W-1:0] kept_base, kept_nl;
	logic              ovf_nl;
	logic [1:0]        verd;
	logic [KEPT_W:0]   idx_inc;
	logic [15:0]       rd_data;

	assign pass_bytes = {pass_hi_q, pass_lo_q};
	assign eff_len    = (len_q > LEN_CAP) ? LEN_CAP : len_q;
	assign eff_len8   = {4'd0, eff_len};

	assign restart    = (cfg_we && cfg_index == REG_PASS_LEN) || cmd.emit_summary;
	assign new_len    = (cfg_we && cfg_index == REG_PASS_LEN) ? cfg_wdata[3:0] : len_q;
	assign search_len = (new_len > LEN_CAP) ? LEN_CAP : new_len;

	assign ch = cmd.take_byte && !done_q && in_byte != NEWLINE_BYTE;
	assign nl = cmd.take_byte && !done_q && in_byte == NEWLINE_BYTE;

	assign byte_hit = (pos_q < eff_len8) && (pass_bytes[pos_q[PB_IDX_W-1:0]] == in_byte);

	// distance = max(length, password length) - matches
	assign longer    = (pos_q > eff_len8) ? pos_q : eff_len8;
	assign word_dist = (longer >= {4'd0, match_q}) ? longer - {4'd0, match_q} : 8'd0;
	assign keep      = word_dist <= best_q;
	assign better    = word_dist < best_q;

	assign kept_base = better ? '0 : kept_q;
	assign room      = kept_base < KEPT_W'(BEST_DEPTH);
	assign kept_nl   = (keep && room) ? kept_base + 1'b1 : kept_q;
	assign ovf_nl    = keep ? (!better && (ovf_q || !room)) : ovf_q;

	always_comb begin
		if (!keep) begin
			verd = VERD_WORSE;
		end else if (word_dist == 8'd0) begin
			verd = VERD_EXACT;
		end else if (better) begin
			verd = VERD_NEW_BEST;
		end else begin
			verd = VERD_TIE;
		end
	end

	nwpm_ram #(
		.WIDTH (16),
		.DEPTH (BEST_DEPTH)
	) u_list (
		.clk   (clk),
		.we    (nl && keep && room),
		.waddr (kept_base[ADDR_W-1:0]),
		.wdata (wnum_q),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign idx_inc = {1'b0, idx_q} + 1'b1;

	assign sts.out_free   = !ov_q || out_ch.ready;
	assign sts.list_empty = kept_q == '0;
	assign sts.idx_last   = idx_inc >= {1'b0, kept_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_lo_q <= '0;
			pass_hi_q <= '0;
			len_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PASS_LO:  pass_lo_q <= cfg_wdata;
				REG_PASS_HI:  pass_hi_q <= cfg_wdata[23:0];
				REG_PASS_LEN: len_q     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= '0;
			wnum_q  <= '0;
			best_q  <= '0;
			kept_q  <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (restart) begin
				pos_q   <= '0;
				match_q <= '0;
				wnum_q  <= '0;
				best_q  <= {4'd0, search_len};
				kept_q  <= '0;
				ovf_q   <= 1'b0;
				done_q  <= 1'b0;
			end else if (ch) begin
				if (byte_hit) begin
					match_q <= match_q + 1'b1;
				end
				if (pos_q != 8'hFF) begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (nl) begin
				pos_q   <= '0;
				match_q <= '0;
				wnum_q  <= wnum_q + 1'b1;
				kept_q  <= kept_nl;
				ovf_q   <= ovf_nl;
				if (better) begin
					best_q <= word_dist;
				end
				if (keep && word_dist == 8'd0) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.flush_start) begin
				idx_q <= '0;
			end else if (cmd.emit_entry) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (nl || cmd.emit_entry || cmd.emit_summary) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (nl) begin
			okind_q <= RK_VERDICT;
			own_q   <= wnum_q;
			odist_q <= word_dist;
			overd_q <= verd;
			okept_q <= OUT_KEPT_W'(kept_nl);
			oovf_q  <= ovf_nl;
			olast_q <= 1'b1;
		end else if (cmd.emit_entry) begin
			okind_q <= RK_ENTRY;
			own_q   <= rd_data;
			odist_q <= best_q;
			overd_q <= VERD_WORSE;
			okept_q <= OUT_KEPT_W'(kept_q);
			oovf_q  <= ovf_q;
			olast_q <= 1'b0;
		end else if (cmd.emit_summary) begin
			okind_q <= RK_SUMMARY;
			own_q   <= wnum_q;
			odist_q <= best_q;
			overd_q <= done_q ? VERD_EXACT : VERD_WORSE;
			okept_q <= OUT_KEPT_W'(kept_q);
			oovf_q  <= ovf_q;
			olast_q <= 1'b1;
		end
	end

	assign out_ch.valid           = ov_q;
	assign out_ch.result_kind     = okind_q;
	assign out_ch.word_number     = own_q;
	assign out_ch.distance        = odist_q;
	assign out_ch.verdict         = overd_q;
	assign out_ch.kept_total      = okept_q;
	assign out_ch.list_overflowed = oovf_q;
	assign out_ch.last_result     = olast_q;

endmodule

/* rtl/nearest_word_positional_match_top.sv */
// Top level of the nearest word positional match search.
//
// in_ch carries the word list one byte per item (kind 0), or a flush (kind 1).
// Byte 10 ends a word; its verdict item appears on out_ch the cycle after the
// newline is taken. Other bytes give no result and are taken one per cycle while
// no flush runs and the output register is free. Words are graded against the
// password set through cfg_we/cfg_index/cfg_wdata: index 0 password bytes 0..7,
// 1 bytes 8..10, 2 length (a length write restarts the search). Up to BEST_DEPTH
// best word indices are kept in a small RAM. A flush walks that list, a RAM read
// then an entry item per kept word, then a summary item with last_result set;
// then a new search starts, and the flush occupies the block until then. After
// an exact match, bytes are taken and dropped until the next flush or restart.
// Results sit in a single output register; while it is full and out_ch.ready
// is low, in_ch.ready drops and nothing is lost. Reset (arst_n low) clears
// the password, the counters and the output valid; the kept list RAM is not
// cleared, only entries written in the current search are ever read.
module nearest_word_positional_match_top import nwpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	nwpm_in_if.sink               in_ch,
	nwpm_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: byte intake and the flush walk
	nwpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.sts      (sts),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	// counters, grading, kept list and result register
	nwpm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_ch.list_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch)
	);

endmodule

/* rtl/nwpm_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module nwpm_checker import nwpm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [15:0] out_word_number,
	input logic [7:0]  out_distance,
	input logic [1:0]  out_verdict,
	input logic [4:0]  out_kept,
	input logic        out_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word_number)
			&& $stable(out_distance))
		else $error("result changed while stalled");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == RK_ENTRY |-> !out_last && out_verdict == VERD_WORSE
			&& out_kept != 5'd0)
		else $error("malformed kept entry");

	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_verdict == VERD_EXACT |-> out_distance == 8'd0 && out_kept != 5'd0
			&& (out_kind == RK_VERDICT || out_kind == RK_SUMMARY))
		else $error("exact match with nonzero distance or empty list");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == RK_VERDICT |-> out_last && out_kept <= 5'(BEST_DEPTH))
		else $error("word verdict not final or list count too large");

endmodule

bind nearest_word_positional_match_top nwpm_checker u_nwpm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_kind        (out_ch.result_kind),
	.out_word_number (out_ch.word_number),
	.out_distance    (out_ch.distance),
	.out_verdict     (out_ch.verdict),
	.out_kept        (out_ch.kept_total),
	.out_last        (out_ch.last_result)
);

/* sim/tb_top.sv */
// Testbench for the nearest word positional match search, with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
	import nwpm_pkg::*;

	// One result item as the block presents it on out_ch.
	typedef struct packed {
		result_kind_t kind;
		logic [15:0]  word_idx;
		logic [7:0]   distance;
		verdict_t     verd;
		logic [4:0]   kept;
		logic         overflow;
		logic         last_flag;
	} word_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	nwpm_in_if  in_ch();
	nwpm_out_if out_ch();

	nearest_word_positional_match_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Search state as the predictor sees it
	logic [63:0] pw_lo;
	logic [23:0] pw_hi;
	logic [3:0]  pw_len;
	int          word_pos;
	int          word_hits;
	logic [15:0] word_count;
	int          best_dist;
	logic [15:0] best_words [BEST_DEPTH];
	int          best_count;
	logic        best_overflow;
	logic        search_stopped;

	word_result_t expected_results[$];

	int  mismatches;
	int  items_sent;
	bit  tx_gaps;
	bit  rx_stalls;
	int  hold_request;
	int  hold_left;
	int  rx_stall_left;

	always #10 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Password length as the block uses it: capped to what the registers hold.
	function automatic int eff_pass_len();
		return (pw_len > LEN_CAP) ? int'(LEN_CAP) : int'(pw_len);
	endfunction

	function automatic logic [7:0] pass_byte(int pos);
		logic [87:0] pw;
		pw = {pw_hi, pw_lo};
		return (pos < PASS_BYTES) ? pw[8*pos +: 8] : 8'd0;
	endfunction

	task automatic restart_search();
		word_pos       = 0;
		word_hits      = 0;
		word_count     = '0;
		best_dist      = eff_pass_len();
		best_count     = 0;
		best_overflow  = 1'b0;
		search_stopped = 1'b0;
	endtask

	// Predict what one accepted input item produces.
	task automatic grade_item(in_kind_t kind, logic [7:0] b);
		int len;
		int longer;
		int word_dist;
		verdict_t v;
		len = eff_pass_len();
		if (kind == KIND_FLUSH) begin
			// Kept entries in keep order, then the summary; the byte is don't-care
			for (int i = 0; i < best_count; i++)
				expected_results.push_back('{RK_ENTRY, best_words[i], 8'(best_dist),
					VERD_WORSE, 5'(best_count), best_overflow, 1'b0});
			expected_results.push_back('{RK_SUMMARY, word_count, 8'(best_dist),
				search_stopped ? VERD_EXACT : VERD_WORSE, 5'(best_count),
				best_overflow, 1'b1});
			restart_search();
		end else if (search_stopped) begin
			// exact match seen: everything up to the flush is dropped
		end else if (b != NEWLINE_BYTE) begin
			if (word_pos < len && pass_byte(word_pos) == b)
				word_hits++;
			if (word_pos < 255)
				word_pos++;
		end else begin
			longer    = (word_pos > len) ? word_pos : len;
			word_dist = longer - word_hits;
			v         = VERD_WORSE;
			if (word_dist <= best_dist) begin
				if (word_dist < best_dist) begin
					best_count    = 0;
					best_overflow = 1'b0;
					best_dist     = word_dist;
					v             = VERD_NEW_BEST;
				end else begin
					v = VERD_TIE;
				end
				// full list: the word is dropped but flagged
				if (best_count < BEST_DEPTH) begin
					best_words[best_count] = word_count;
					best_count++;
				end else begin
					best_overflow = 1'b1;
				end
				if (word_dist == 0) begin
					v              = VERD_EXACT;
					search_stopped = 1'b1;
				end
			end
			expected_results.push_back('{RK_VERDICT, word_count, 8'(word_dist), v,
				5'(best_count), best_overflow, 1'b1});
			word_pos   = 0;
			word_hits  = 0;
			word_count = word_count + 16'd1;
		end
	endtask

	// Offer one item after an optional gap; returns on the accepting edge.
	// valid is left high so a back-to-back item needs no extra toggle.
	task automatic send_item(in_kind_t kind, logic [7:0] b);
		int gap;
		gap = tx_gaps ? gap_len() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.kind      <= kind;
		in_ch.list_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		grade_item(kind, b);
		items_sent++;
	endtask

	// Byte at a word position, biased toward a hit on the password byte.
	function automatic logic [7:0] word_byte(int pos);
		logic [7:0] r;
		if (pos < PASS_BYTES && $urandom_range(0, 99) < 70)
			return pass_byte(pos);
		r = 8'($urandom_range(0, 255));
		return (r == NEWLINE_BYTE) ? 8'hF5 : r;
	endfunction

	task automatic send_word(int n);
		for (int p = 0; p < n; p++)
			send_item(KIND_BYTE, word_byte(p));
		send_item(KIND_BYTE, NEWLINE_BYTE);
	endtask

	task automatic idle_cycles(int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drain all results; the extra cycles cover bytes still in flight that
	// produce nothing.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_PASS_LO: begin
				pw_lo = v;
			end
			REG_PASS_HI: begin
				pw_hi = v[23:0];
			end
			REG_PASS_LEN: begin
				pw_len = v[3:0];
				restart_search();
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Out of reset the length is zero, so an empty word is already exact.
	task automatic test_reset_state();
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_BYTE, "x");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_FLUSH, 8'h00);
		// nothing kept: summary only
		send_item(KIND_FLUSH, 8'hA5);
		wait_idle();
	endtask

	// Password "abcde": new best, worse, tie, byte extremes, exact, then stop.
	task automatic test_directed_grading();
		write_reg(REG_PASS_LO, 64'h6867_6665_6463_6261);
		write_reg(REG_PASS_HI, 64'h6B_6A69);
		write_reg(REG_PASS_LEN, 64'd5);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, "c");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, "d");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, "c");
		send_item(KIND_BYTE, "x");
		send_item(KIND_BYTE, "x");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, "c");
		send_item(KIND_BYTE, "d");
		send_item(KIND_BYTE, "e");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		// after the exact match these are dropped
		send_item(KIND_BYTE, "q");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_FLUSH, 8'hFF);
		wait_idle();
	endtask

	// Length write mid-word restarts; an unterminated word is lost at flush.
	task automatic test_length_restart();
		write_reg(REG_PASS_LEN, 64'd4);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, "c");
		wait_idle();
		write_reg(REG_PASS_LEN, 64'd2);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "b");
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_FLUSH, 8'h0A);
		send_item(KIND_BYTE, "a");
		send_item(KIND_BYTE, "z");
		send_item(KIND_FLUSH, 8'h00);
		wait_idle();
	endtask

	// Lengths above the cap, with junk in the upper write data bits.
	task automatic test_oversized_length();
		write_reg(REG_PASS_LO, {$urandom, $urandom});
		write_reg(REG_PASS_HI, {$urandom, $urandom});
		write_reg(REG_PASS_LEN, 64'd15);
		for (int p = 0; p < PASS_BYTES; p++)
			send_item(KIND_BYTE, (pass_byte(p) == NEWLINE_BYTE) ? 8'h00 : pass_byte(p));
		send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_FLUSH, 8'h3C);
		wait_idle();
		write_reg(REG_PASS_LEN, 64'hFFFF_FFFF_FFFF_FFFC);
		send_word(13);
		send_word(11);
		send_word(4);
		send_item(KIND_FLUSH, 8'hC3);
		wait_idle();
	endtask

	// 300-byte word: position saturates at 255.
	task automatic test_long_word();
		write_reg(REG_PASS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PASS_HI, 64'hFF_FFFF);
		write_reg(REG_PASS_LEN, 64'd11);
		send_word(300);
		send_word(6);
		send_item(KIND_FLUSH, 8'h55);
		wait_idle();
	endtask

	// 40 empty words all tie at the start bound, so the kept list overflows.
	task automatic test_list_overflow();
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		write_reg(REG_PASS_LEN, 64'd3);
		for (int i = 0; i < 40; i++)
			send_item(KIND_BYTE, NEWLINE_BYTE);
		send_item(KIND_FLUSH, 8'h00);
		wait_idle();
	endtask

	// Receiver holds off for a long stretch while words keep coming, so the
	// output register fills and the input has to stall.
	task automatic test_backpressure();
		tx_gaps   = 1'b0;
		rx_stalls = 1'b1;
		write_reg(REG_PASS_LEN, 64'd3);
		hold_request = 300;
		idle_cycles(2);
		for (int w = 0; w < 15; w++)
			send_word(3);
		send_item(KIND_FLUSH, 8'h00);
		wait_idle();
	endtask

	// Mostly well-formed words over several password settings, plus noise
	// items and words cut short by a flush.
	task automatic test_random_search();
		int start;
		int phase_start;
		int len;
		int r;
		int n;
		logic [63:0] len_val;
		start = items_sent;
		for (int phase = 0; items_sent - start < 230; phase++) begin
			tx_gaps   = (phase % 3 != 1);
			rx_stalls = (phase % 3 != 2);
			case (phase % 5)
				0: len_val = 64'd11;
				1: len_val = 64'($urandom_range(1, 10));
				2: len_val = {$urandom, $urandom} | 64'hF;
				3: len_val = 64'($urandom_range(0, 15));
				default: len_val = 64'($urandom_range(1, 11));
			endcase
			write_reg(REG_PASS_LO, {$urandom, $urandom});
			write_reg(REG_PASS_HI, {$urandom, $urandom});
			write_reg(REG_PASS_LEN, len_val);
			len = eff_pass_len();
			phase_start = items_sent;
			while (items_sent - phase_start < 45) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					n = ($urandom_range(0, 9) != 0) ? $urandom_range(0, len + 2)
						: $urandom_range(len + 3, 20);
					send_word(n);
				end else if (r < 88) begin
					send_item(in_kind_t'($urandom_range(0, 1)), 8'($urandom));
				end else if (r < 94) begin
					n = $urandom_range(1, 5);
					for (int p = 0; p < n; p++)
						send_item(KIND_BYTE, word_byte(p));
					send_item(KIND_FLUSH, 8'($urandom));
				end else begin
					send_item(KIND_FLUSH, 8'($urandom));
				end
			end
			send_item(KIND_FLUSH, 8'($urandom));
			wait_idle();
		end
	endtask

	// Result sink: random stalls, plus the long hold-off on request.
	always @(posedge clk) begin : receiver
		int n;
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_request > 0) begin
			out_ch.ready <= 1'b0;
			hold_left = hold_request - 1;
			hold_request = 0;
		end else if (rx_stall_left > 0) begin
			out_ch.ready <= 1'b0;
			rx_stall_left--;
		end else if (rx_stalls) begin
			n = gap_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				rx_stall_left = n - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		word_result_t got;
		word_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{result_kind_t'(out_ch.result_kind), out_ch.word_number, out_ch.distance,
				verdict_t'(out_ch.verdict), out_ch.kept_total, out_ch.list_overflowed,
				out_ch.last_result};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result kind=%0d word=%0d dist=%0d verdict=%0d",
						$realtime, got.kind, got.word_idx, got.distance, got.verd);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  exp kind=%0d word=%0d dist=%0d verdict=%0d kept=%0d ovf=%0d last=%0d",
							want.kind, want.word_idx, want.distance, want.verd, want.kept,
							want.overflow, want.last_flag);
						$display("  got kind=%0d word=%0d dist=%0d verdict=%0d kept=%0d ovf=%0d last=%0d",
							got.kind, got.word_idx, got.distance, got.verd, got.kept,
							got.overflow, got.last_flag);
					end
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_PASS_LO;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.kind      = KIND_BYTE;
		in_ch.list_byte = 8'h00;
		out_ch.ready    = 1'b0;
		mismatches      = 0;
		items_sent      = 0;
		tx_gaps         = 1'b1;
		rx_stalls       = 1'b1;
		hold_request    = 0;
		hold_left       = 0;
		rx_stall_left   = 0;
		pw_lo           = '0;
		pw_hi           = '0;
		pw_len          = '0;
		restart_search();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_grading();
		test_length_restart();
		test_oversized_length();
		test_long_word();
		test_backpressure();
		test_list_overflow();
		test_random_search();

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
